// ===== design/eihp_pkg.sv =====
// Shared types and constants for the Ethernet/IPv4/L4 header parser.
`default_nettype none

package eihp_pkg;

  localparam int CFG_W  = 16;   // widest configuration register
  localparam int PAY_W  = 18;   // working width of the payload length sum
  localparam int HOFF_W = 7;    // transport header offset, 14 + 4*15 at most

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam int          ETH_HDR_BYTES  = 14;
  localparam int          IP_MIN_BYTES   = 20;

  localparam logic [CFG_W-1:0] HTTP_PORT_RST = 16'd80;
  localparam logic [CFG_W-1:0] TLS_PORT_RST  = 16'd443;

  localparam logic signed [PAY_W-1:0] PAY_POS_LIMIT = 18'sd32767;
  localparam logic signed [PAY_W-1:0] PAY_NEG_LIMIT = -18'sd32768;

  // configuration register indexes
  typedef enum logic {
    REG_HTTP_PORT = 1'b0,
    REG_TLS_PORT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_ETH = 3'd1,
    ST_SHORT_IP  = 3'd2,
    ST_NOT_IPV4  = 3'd3,
    ST_SHORT_L4  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    APP_NONE = 2'd0,
    APP_HTTP = 2'd1,
    APP_TLS  = 2'd2
  } app_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [47:0]        dest_mac;
    logic [47:0]        source_mac;
    logic [31:0]        source_ip;
    logic [31:0]        dest_ip;
    logic [7:0]         ip_protocol;
    logic [15:0]        source_port;
    logic [15:0]        dest_port;
    logic [7:0]         tcp_flag_bits;
    logic [15:0]        tcp_window;
    app_class_t         app_class;
    logic signed [15:0] payload_length;
  } out_item_t;

  // header fields gathered over one frame
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] l2_type;
    logic [3:0]  ip_header_words;
    logic [7:0]  protocol;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [3:0]  tcp_offset_words;
    logic [7:0]  flags;
    logic [15:0] window;
  } frame_hdr_t;

endpackage

`default_nettype wire

// ===== design/eihp_in_if.sv =====
// Byte channel into the header parser.
`default_nettype none

interface eihp_in_if import eihp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/eihp_out_if.sv =====
// Result channel out of the header parser.
`default_nettype none

interface eihp_out_if import eihp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/eihp_capture.sv =====
// Input register, byte counter, header field capture and end-of-frame snapshot.
`default_nettype none

module eihp_capture import eihp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 16384,
  parameter int CW              = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  eihp_in_if.sink            frame,
  output logic               snap_valid,
  input  wire logic          snap_ready,
  output logic [CW-1:0]      snap_count,
  output frame_hdr_t         snap_hdr
);

  logic          in_valid;
  in_item_t      in_item;
  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  frame_hdr_t    hdr;
  frame_hdr_t    hdr_next;

  logic              consume;
  logic              in_adv;
  logic              snap_adv;
  logic              load;
  logic              cap;
  logic [3:0]        ihl_eff;
  logic [CW-1:0]     l4_off;
  logic [CW-1:0]     p;
  logic [7:0]        b;

  assign snap_adv = !snap_valid || snap_ready;
  // a last word waits only if the snapshot cannot move on
  assign consume  = in_valid && (!in_item.last_byte || snap_adv);
  assign in_adv   = !in_valid || consume;
  assign load     = consume && in_item.last_byte;
  assign frame.ready = in_adv;

  assign p   = byte_count;
  assign b   = in_item.data_byte;
  assign cap = consume && (byte_count < CW'(MAX_FRAME_BYTES));
  // IHL taken on this very byte already moves the transport offset
  assign ihl_eff = (p == CW'(ETH_HDR_BYTES)) ? b[3:0] : hdr.ip_header_words;
  assign l4_off  = CW'(ETH_HDR_BYTES) + CW'({ihl_eff, 2'b00});

  always_comb begin
    hdr_next        = hdr;
    byte_count_next = byte_count;
    if (cap) begin
      byte_count_next = byte_count + CW'(1);
      if (p < CW'(6)) begin
        hdr_next.dest_mac = {hdr.dest_mac[39:0], b};
      end else if (p < CW'(12)) begin
        hdr_next.source_mac = {hdr.source_mac[39:0], b};
      end else if (p < CW'(14)) begin
        hdr_next.l2_type = {hdr.l2_type[7:0], b};
      end
      if (p == CW'(14)) begin
        hdr_next.ip_header_words = b[3:0];
      end
      if (p == CW'(23)) begin
        hdr_next.protocol = b;
      end
      if (p inside {[26:29]}) begin
        hdr_next.source_ip = {hdr.source_ip[23:0], b};
      end
      if (p inside {[30:33]}) begin
        hdr_next.dest_ip = {hdr.dest_ip[23:0], b};
      end
      if (p >= l4_off && p < l4_off + CW'(2)) begin
        hdr_next.source_port = {hdr.source_port[7:0], b};
      end
      if (p >= l4_off + CW'(2) && p < l4_off + CW'(4)) begin
        hdr_next.dest_port = {hdr.dest_port[7:0], b};
      end
      if (p == l4_off + CW'(12)) begin
        hdr_next.tcp_offset_words = b[7:4];
      end
      if (p == l4_off + CW'(13)) begin
        hdr_next.flags = b;
      end
      if (p >= l4_off + CW'(14) && p < l4_off + CW'(16)) begin
        hdr_next.window = {hdr.window[7:0], b};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_adv) begin
      in_valid <= frame.valid;
    end
    if (in_adv) begin
      in_item <= frame.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      hdr        <= '0;
    end else if (load) begin
      // frame done: clear for the next one
      byte_count <= '0;
      hdr        <= '0;
    end else if (consume) begin
      byte_count <= byte_count_next;
      hdr        <= hdr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_adv) begin
      snap_valid <= load;
    end
    if (load) begin
      snap_count <= byte_count_next;
      snap_hdr   <= hdr_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/eihp_result.sv =====
// Status checks, field selection, port classification and the result register.
`default_nettype none

module eihp_result import eihp_pkg::*; #(
  parameter int CW = 15
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             snap_valid,
  output logic                  snap_ready,
  input  wire logic [CW-1:0]    snap_count,
  input  frame_hdr_t            snap_hdr,
  eihp_out_if.source            result
);

  logic [CFG_W-1:0]         http_port;
  logic [CFG_W-1:0]         tls_port;
  logic                     out_adv;
  out_item_t                item;
  logic [HOFF_W-1:0]        l4_off;
  logic signed [PAY_W-1:0]  pay;
  logic                     is_tcp;
  logic                     is_udp;

  assign out_adv      = !result.valid || result.ready;
  assign snap_ready   = out_adv;

  assign l4_off = HOFF_W'(ETH_HDR_BYTES) + HOFF_W'({snap_hdr.ip_header_words, 2'b00});
  assign is_tcp = snap_hdr.protocol == PROTO_TCP;
  assign is_udp = snap_hdr.protocol == PROTO_UDP;

  always_comb begin
    pay = $signed(PAY_W'(snap_count) - PAY_W'(l4_off));
    if (is_tcp) begin
      pay = pay - $signed(PAY_W'({snap_hdr.tcp_offset_words, 2'b00}));
    end
  end

  always_comb begin
    item = '0;
    if (snap_count < CW'(ETH_HDR_BYTES)) begin
      item.status = ST_SHORT_ETH;
    end else if (snap_count < CW'(ETH_HDR_BYTES + IP_MIN_BYTES)) begin
      item.status = ST_SHORT_IP;
    end else if (snap_hdr.l2_type != ETHERTYPE_IPV4) begin
      item.status = ST_NOT_IPV4;
    end else if (snap_count < CW'(l4_off)) begin
      item.status = ST_SHORT_L4;
    end else begin
      item.status = ST_OK;
    end

    if (item.status != ST_SHORT_ETH) begin
      item.dest_mac   = snap_hdr.dest_mac;
      item.source_mac = snap_hdr.source_mac;
    end
    if (item.status == ST_SHORT_L4 || item.status == ST_OK) begin
      item.source_ip   = snap_hdr.source_ip;
      item.dest_ip     = snap_hdr.dest_ip;
      item.ip_protocol = snap_hdr.protocol;
    end
    if (item.status == ST_OK) begin
      if (is_tcp || is_udp) begin
        item.source_port = snap_hdr.source_port;
        item.dest_port   = snap_hdr.dest_port;
      end
      if (is_tcp) begin
        item.tcp_flag_bits = snap_hdr.flags;
        item.tcp_window    = snap_hdr.window;
        if (snap_hdr.source_port == http_port || snap_hdr.dest_port == http_port) begin
          item.app_class = APP_HTTP;
        end else if (snap_hdr.source_port == tls_port || snap_hdr.dest_port == tls_port) begin
          item.app_class = APP_TLS;
        end
      end
      // clamp to the signed 16-bit range
      if (pay > PAY_POS_LIMIT) begin
        item.payload_length = 16'sh7FFF;
      end else if (pay < PAY_NEG_LIMIT) begin
        item.payload_length = -16'sh8000;
      end else begin
        item.payload_length = pay[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      http_port <= HTTP_PORT_RST;
      tls_port  <= TLS_PORT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HTTP_PORT: http_port <= cfg_data;
        REG_TLS_PORT:  tls_port  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_adv) begin
      result.valid <= snap_valid;
    end
    if (out_adv && snap_valid) begin
      result.data <= item;
    end
  end

endmodule

`default_nettype wire

// ===== design/eth_ipv4_l4_header_parser.sv =====
// Top level of the Ethernet/IPv4/TCP-UDP header parser.
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+-------------------------------------------
//   frame    | in  | valid/ready   | data_byte, last_byte
//   result   | out | valid/ready   | status, MACs, IPs, ports, TCP fields, class
//   cfg      | in  | cfg_we only   | cfg_index selects http_port / tls_port
//
// One frame word is taken every cycle, but a last word waits while the
// snapshot register cannot move on. Once the last word is in the input
// register, its result is loaded into the snapshot, then the result register.
// A stalled result holds; frame words keep flowing until a second last word
// finds both the snapshot and the result register full.
// Synchronous reset clears the counter, the captured fields and all valid flags.
`default_nettype none

module eth_ipv4_l4_header_parser import eihp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  wire logic             clk,
  input  wire logic             rst,
  eihp_in_if.sink               frame,
  eihp_out_if.source            result,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  logic          snap_valid;
  logic          snap_ready;
  logic [CW-1:0] snap_count;
  frame_hdr_t    snap_hdr;

  eihp_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .CW(CW)
  ) u_capture (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap_count(snap_count),
    .snap_hdr  (snap_hdr)
  );

  eihp_result #(
    .CW(CW)
  ) u_result (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap_count(snap_count),
    .snap_hdr  (snap_hdr),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== design/eihp_checker.sv =====
// Port-level checks for the header parser, bound to the top level.
`default_nettype none

module eihp_checker import eihp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  // an empty result register means the pipe behind it can always drain
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("frame stalled with an empty result register");

  a_fail_no_l4: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.payload_length == 16'sd0 && out_data.app_class == APP_NONE &&
      out_data.source_port == 16'd0 && out_data.tcp_window == 16'd0)
    else $error("transport fields given on a failed parse");

endmodule

bind eth_ipv4_l4_header_parser eihp_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (frame.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_data (result.data)
);

`default_nettype wire

// ===== dv/eihp_checker.sv =====
// Predicts header parser results from the observed byte stream and compares them.
`default_nettype none

module eihp_scoreboard import eihp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             frame_valid,
  input  wire logic             frame_ready,
  input  wire in_item_t         frame_data,
  input  wire logic             result_valid,
  input  wire logic             result_ready,
  input  wire out_item_t        result_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    tcp_ok_results
);

  logic [CFG_W-1:0] http_port_cfg;
  logic [CFG_W-1:0] tls_port_cfg;
  int               bytes_in_frame;
  frame_hdr_t       hdr;
  out_item_t        expected_results[$];
  out_item_t        want;

  // capture one byte at its frame offset; transport offset follows the IHL seen so far
  function automatic void capture_byte(input int p, input logic [7:0] b);
    int hoff;
    if (p < 6) hdr.dest_mac = {hdr.dest_mac[39:0], b};
    else if (p < 12) hdr.source_mac = {hdr.source_mac[39:0], b};
    else if (p < 14) hdr.l2_type = {hdr.l2_type[7:0], b};
    if (p == 14) hdr.ip_header_words = b[3:0];
    if (p == 23) hdr.protocol = b;
    if (p >= 26 && p < 30) hdr.source_ip = {hdr.source_ip[23:0], b};
    if (p >= 30 && p < 34) hdr.dest_ip = {hdr.dest_ip[23:0], b};
    hoff = ETH_HDR_BYTES + 4 * int'(hdr.ip_header_words);
    if (p >= hoff && p < hoff + 2) hdr.source_port = {hdr.source_port[7:0], b};
    if (p >= hoff + 2 && p < hoff + 4) hdr.dest_port = {hdr.dest_port[7:0], b};
    if (p == hoff + 12) hdr.tcp_offset_words = b[7:4];
    if (p == hoff + 13) hdr.flags = b;
    if (p >= hoff + 14 && p < hoff + 16) hdr.window = {hdr.window[7:0], b};
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    out_item_t r;
    int        hoff;
    int        pay;
    if (bytes_in_frame < MAX_FRAME_BYTES) begin
      capture_byte(bytes_in_frame, b);
      bytes_in_frame++;
    end
    if (!last) return;

    r = '0;
    hoff = ETH_HDR_BYTES + 4 * int'(hdr.ip_header_words);
    if (bytes_in_frame < ETH_HDR_BYTES) r.status = ST_SHORT_ETH;
    else if (bytes_in_frame < ETH_HDR_BYTES + IP_MIN_BYTES) r.status = ST_SHORT_IP;
    else if (hdr.l2_type != ETHERTYPE_IPV4) r.status = ST_NOT_IPV4;
    else if (bytes_in_frame < hoff) r.status = ST_SHORT_L4;
    else r.status = ST_OK;

    if (r.status != ST_SHORT_ETH) begin
      r.dest_mac   = hdr.dest_mac;
      r.source_mac = hdr.source_mac;
    end
    if (r.status == ST_SHORT_L4 || r.status == ST_OK) begin
      r.source_ip   = hdr.source_ip;
      r.dest_ip     = hdr.dest_ip;
      r.ip_protocol = hdr.protocol;
    end
    if (r.status == ST_OK) begin
      pay = bytes_in_frame - hoff;
      if (hdr.protocol == PROTO_TCP) begin
        r.source_port   = hdr.source_port;
        r.dest_port     = hdr.dest_port;
        r.tcp_flag_bits = hdr.flags;
        r.tcp_window    = hdr.window;
        if (hdr.source_port == http_port_cfg || hdr.dest_port == http_port_cfg)
          r.app_class = APP_HTTP;
        else if (hdr.source_port == tls_port_cfg || hdr.dest_port == tls_port_cfg)
          r.app_class = APP_TLS;
        else
          r.app_class = APP_NONE;
        pay = pay - 4 * int'(hdr.tcp_offset_words);
      end else if (hdr.protocol == PROTO_UDP) begin
        r.source_port = hdr.source_port;
        r.dest_port   = hdr.dest_port;
      end
      if (pay > 32767) pay = 32767;
      if (pay < -32768) pay = -32768;
      r.payload_length = 16'(pay);
    end

    expected_results.push_back(r);
    hdr = '0;
    bytes_in_frame = 0;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      http_port_cfg = HTTP_PORT_RST;
      tls_port_cfg  = TLS_PORT_RST;
      hdr = '0;
      bytes_in_frame = 0;
      expected_results.delete();
      fail_count = 0;
      pending = 0;
      results_checked = 0;
      tcp_ok_results = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected, status %0d", result_data.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, result_data.status);
          check_field("dest_mac", want.dest_mac, result_data.dest_mac);
          check_field("source_mac", want.source_mac, result_data.source_mac);
          check_field("source_ip", want.source_ip, result_data.source_ip);
          check_field("dest_ip", want.dest_ip, result_data.dest_ip);
          check_field("ip_protocol", want.ip_protocol, result_data.ip_protocol);
          check_field("source_port", want.source_port, result_data.source_port);
          check_field("dest_port", want.dest_port, result_data.dest_port);
          check_field("tcp_flag_bits", want.tcp_flag_bits, result_data.tcp_flag_bits);
          check_field("tcp_window", want.tcp_window, result_data.tcp_window);
          check_field("app_class", want.app_class, result_data.app_class);
          check_field("payload_length", {48'd0, want.payload_length},
                      {48'd0, result_data.payload_length});
          results_checked++;
          if (want.status == ST_OK && want.ip_protocol == PROTO_TCP) tcp_ok_results++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_HTTP_PORT) http_port_cfg = cfg_data;
        else tls_port_cfg = cfg_data;
      end
      if (frame_valid && frame_ready)
        parse_byte(frame_data.data_byte, frame_data.last_byte);
      pending = expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Stimulus, port setup and verdict for the Ethernet/IPv4/L4 header parser.
`default_nettype none

module tb_top;
  import eihp_pkg::*;

  localparam int FRAME_BOUND  = 16384;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  eihp_in_if  frame ();
  eihp_out_if result ();

  int fail_count;
  int pending;
  int results_checked;
  int tcp_ok_results;

  int          cycles = 0;
  logic        steady;
  int          hold_reqs;
  int          hold_served;
  int          hold_left;
  logic [15:0] http_now;
  logic [15:0] tls_now;
  logic [7:0]  pkt[$];
  int          sent_bytes;
  int          sent_frames;

  eth_ipv4_l4_header_parser #(.MAX_FRAME_BYTES(FRAME_BOUND)) u_top (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  eihp_scoreboard #(.MAX_FRAME_BYTES(FRAME_BOUND)) u_chk (
    .clk             (clk),
    .rst             (rst),
    .frame_valid     (frame.valid),
    .frame_ready     (frame.ready),
    .frame_data      (frame.data),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_data     (result.data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .tcp_ok_results  (tcp_ok_results)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random back-pressure, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      hold_left    <= 0;
      hold_served  <= 0;
    end else if (hold_left != 0) begin
      result.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      result.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_served  <= hold_served + 1;
    end else begin
      result.ready <= steady || ($urandom_range(99) >= 25);
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 25) begin
      frame.valid <= 1'b0;
      @(posedge clk);
    end
    frame.valid <= 1'b1;
    frame.data  <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!frame.ready);
    sent_bytes++;
  endtask

  task automatic send_pkt();
    for (int i = 0; i < pkt.size(); i++) put_byte(pkt[i], i == pkt.size() - 1);
    sent_frames++;
  endtask

  function automatic void poke(input int idx, input logic [7:0] v);
    if (idx < pkt.size()) pkt[idx] = v;
  endfunction

  function automatic void fill_pkt(input int len, input logic [7:0] v, input logic rnd);
    pkt.delete();
    repeat (len) pkt.push_back(rnd ? 8'($urandom) : v);
  endfunction

  // IPv4 frame with random content; keep > 0 cuts it short
  function automatic void build_frame(input logic [3:0] ihl, input logic [7:0] proto,
                                      input logic [3:0] doff, input logic [15:0] sp,
                                      input logic [15:0] dp, input int pay,
                                      input int keep);
    int hoff;
    int full;
    hoff = ETH_HDR_BYTES + 4 * int'(ihl);
    full = hoff + ((proto == PROTO_TCP) ? 4 * int'(doff) : 8) + pay;
    if (full < ETH_HDR_BYTES + IP_MIN_BYTES) full = ETH_HDR_BYTES + IP_MIN_BYTES;
    if (keep > 0 && keep < full) full = keep;
    fill_pkt(full, 8'h00, 1'b1);
    poke(12, ETHERTYPE_IPV4[15:8]);
    poke(13, ETHERTYPE_IPV4[7:0]);
    poke(23, proto);
    poke(hoff, sp[15:8]);
    poke(hoff + 1, sp[7:0]);
    poke(hoff + 2, dp[15:8]);
    poke(hoff + 3, dp[7:0]);
    if (proto == PROTO_TCP) poke(hoff + 12, {doff, 4'($urandom)});
    // IHL last so the intended transport offset holds even when headers overlap
    poke(14, {4'h4, ihl});
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(4))
      0: return http_now;
      1: return tls_now;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic noise_frame(input int max_len);
    fill_pkt($urandom_range(1, max_len), 8'h00, 1'b1);
    if ($urandom_range(1) == 1) begin
      poke(12, ETHERTYPE_IPV4[15:8]);
      poke(13, ETHERTYPE_IPV4[7:0]);
    end
    send_pkt();
  endtask

  task automatic random_frame();
    int         r;
    int         keep;
    logic [3:0] ihl;
    logic [3:0] doff;
    logic [7:0] proto;
    r     = $urandom_range(99);
    ihl   = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
    doff  = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
    keep  = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : 0;
    if (r < 55) proto = PROTO_TCP;
    else if (r < 75) proto = PROTO_UDP;
    else proto = 8'($urandom);
    if (r < 85) begin
      build_frame(ihl, proto, doff, pick_port(), pick_port(), $urandom_range(24), keep);
      // break the ethertype on a share of the frames
      if (r >= 80) poke(13, 8'($urandom_range(1, 255)));
      send_pkt();
    end else begin
      noise_frame(40);
    end
  endtask

  task automatic run_random(input int min_bytes, input int min_frames);
    int b0;
    int f0;
    b0 = sent_bytes;
    f0 = sent_frames;
    while (sent_bytes - b0 < min_bytes || sent_frames - f0 < min_frames) random_frame();
  endtask

  task automatic drain();
    frame.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_ports(input logic [15:0] h, input logic [15:0] t);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_HTTP_PORT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_TLS_PORT;
    cfg_data  <= t;
    @(posedge clk);
    cfg_we    <= 1'b0;
    http_now = h;
    tls_now  = t;
  endtask

  task automatic directed_frames();
    fill_pkt(1, 8'hff, 1'b0);
    send_pkt();
    fill_pkt(13, 8'hff, 1'b0);
    send_pkt();
    fill_pkt(14, 8'h00, 1'b0);
    send_pkt();
    // short for IPv4 wins over a good ethertype
    fill_pkt(33, 8'hff, 1'b0);
    poke(12, 8'h08);
    poke(13, 8'h00);
    send_pkt();
    fill_pkt(34, 8'h00, 1'b1);
    poke(12, 8'h86);
    poke(13, 8'hdd);
    send_pkt();
    // long IP options, frame ends before the transport header
    build_frame(4'd15, PROTO_TCP, 4'd5, 16'd80, 16'd80, 0, 60);
    send_pkt();
    build_frame(4'd5, PROTO_TCP, 4'd5, 16'd80, 16'd1234, 4, 0);
    send_pkt();
    build_frame(4'd5, PROTO_TCP, 4'd5, 16'd5000, 16'd443, 0, 0);
    send_pkt();
    build_frame(4'd5, PROTO_TCP, 4'd5, 16'd443, 16'd80, 9, 0);
    send_pkt();
    build_frame(4'd5, PROTO_UDP, 4'd0, 16'hffff, 16'h0000, 0, 0);
    send_pkt();
    build_frame(4'd5, 8'd1, 4'd0, 16'd80, 16'd443, 6, 0);
    send_pkt();
    // IHL of zero: transport header overlaps the IP header
    build_frame(4'd0, PROTO_TCP, 4'd5, 16'd443, 16'd7, 3, 0);
    send_pkt();
    // large data offset in a short frame: negative payload
    build_frame(4'd5, PROTO_TCP, 4'd15, 16'd80, 16'd22, 0, 54);
    send_pkt();
    // transport ports cut off by the frame end
    build_frame(4'd5, PROTO_TCP, 4'd5, 16'habcd, 16'h1234, 0, 35);
    send_pkt();
    build_frame(4'd5, PROTO_TCP, 4'd5, 16'd80, 16'd80, 0, 34);
    send_pkt();
    // all ones with a valid ethertype
    fill_pkt(80, 8'hff, 1'b0);
    poke(12, 8'h08);
    poke(13, 8'h00);
    send_pkt();
    fill_pkt(64, 8'h00, 1'b0);
    poke(12, 8'h08);
    poke(14, 8'h45);
    send_pkt();
  endtask

  initial begin
    rst         <= 1'b1;
    frame.valid <= 1'b0;
    frame.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_HTTP_PORT;
    cfg_data    <= '0;
    hold_reqs   <= 0;
    steady      = 1'b0;
    http_now    = HTTP_PORT_RST;
    tls_now     = TLS_PORT_RST;
    sent_bytes  = 0;
    sent_frames = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    directed_frames();

    // extremes, run without any idling on either side
    set_ports(16'h0000, 16'hffff);
    steady = 1'b1;
    run_random(150, 2);
    steady = 1'b0;

    // swapped extremes, with a long result hold-off over a burst of tiny frames
    set_ports(16'hffff, 16'h0000);
    run_random(60, 1);
    hold_reqs <= hold_reqs + 1;
    repeat (40) noise_frame(3);
    run_random(60, 1);

    // equal ports: HTTP must take precedence
    set_ports(16'($urandom), 16'h0000);
    set_ports(http_now, http_now);
    run_random(60, 1);

    set_ports(16'($urandom), 16'($urandom));
    run_random(60, 1);
    run_random(30, 1);

    drain();
    repeat (10) @(posedge clk);
    $display("Checked %0d result words (%0d good TCP) from %0d frames of %0d bytes.",
             results_checked, tcp_ok_results, sent_frames, sent_bytes);
    $display("Port settings: reset, both extremes, equal and random; short and odd headers.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
